FILE: sv/sss_pkg.sv
`default_nettype none

package sss_pkg;

    localparam int DEPTH   = 256;
    localparam int VALUE_W = 32;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);

    typedef logic [ADDR_W-1:0]         t_addr;
    typedef logic [CNT_W-1:0]          t_cnt;
    typedef logic signed [VALUE_W-1:0] t_value;

    typedef enum logic [1:0] {
        CMD_PUSH      = 2'd0,
        CMD_POP_FRONT = 2'd1,
        CMD_POP_BACK  = 2'd2,
        CMD_SORT      = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } t_status;

    typedef struct packed {
        t_cmd               command;
        logic signed [31:0] data_value;
        logic               descending;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] popped_value;
        logic [8:0]         item_count;
        t_status            status;
    } t_out_item;

    // One request to the two memories: shared read and write addresses,
    // separate write enables for the store and the scratch buffer.
    typedef struct packed {
        t_addr  ra;
        t_addr  rb;
        t_addr  wa;
        t_value wd;
        logic   we_s;
        logic   we_t;
    } t_mem_req;

endpackage

`default_nettype wire

FILE: sv/sss_ram.sv
`default_nettype none

module sss_ram #(
    parameter int ADDR_W = sss_pkg::ADDR_W,
    parameter int DATA_W = sss_pkg::VALUE_W
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_wa,
    input  wire logic [DATA_W-1:0] i_wd,
    input  wire logic [ADDR_W-1:0] i_ra,
    input  wire logic [ADDR_W-1:0] i_rb,
    output logic      [DATA_W-1:0] o_qa,
    output logic      [DATA_W-1:0] o_qb
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wa] <= i_wd;
        end
    end

    // Registered read on both ports.
    always_ff @(posedge i_clk) begin
        o_qa <= r_mem[i_ra];
        o_qb <= r_mem[i_rb];
    end

endmodule

`default_nettype wire

FILE: sv/sss_sorter.sv
`default_nettype none

module sss_sorter (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic              i_desc,
    input  wire sss_pkg::t_cnt     i_count,
    input  wire sss_pkg::t_addr    i_front,
    input  wire sss_pkg::t_value   i_s_qa,
    input  wire sss_pkg::t_value   i_s_qb,
    input  wire sss_pkg::t_value   i_t_qa,
    input  wire sss_pkg::t_value   i_t_qb,
    output sss_pkg::t_mem_req      o_mem,
    output logic                   o_busy,
    output logic                   o_done
);

    import sss_pkg::*;

    typedef enum logic [8:0] {
        SR_IDLE    = 9'b000000001,
        SR_CIN_RD  = 9'b000000010,
        SR_CIN_WR  = 9'b000000100,
        SR_SETUP   = 9'b000001000,
        SR_M_RD    = 9'b000010000,
        SR_M_WR    = 9'b000100000,
        SR_COUT_RD = 9'b001000000,
        SR_COUT_WR = 9'b010000000,
        SR_DONE    = 9'b100000000
    } t_sr_state;

    t_sr_state r_state, n_state;
    t_cnt      r_n, n_n;
    t_addr     r_front, n_front;
    logic      r_desc, n_desc;
    logic      r_src_t, n_src_t;
    t_cnt      r_c, n_c;
    t_cnt      r_w, n_w;
    t_cnt      r_lo, n_lo;
    t_cnt      r_mid, n_mid;
    t_cnt      r_hi, n_hi;
    t_cnt      r_i, n_i;
    t_cnt      r_j, n_j;
    t_cnt      r_k, n_k;

    logic [CNT_W:0] sum_mid;
    logic [CNT_W:0] sum_hi;
    logic [CNT_W:0] w2;
    t_value         a;
    t_value         b;
    logic           cmp;
    logic           take_left;
    t_cnt           k_next;
    t_cnt           c_next;

    assign sum_mid = {1'b0, r_lo} + {1'b0, r_w};
    assign sum_hi  = {1'b0, r_lo} + {r_w, 1'b0};
    assign w2      = {r_w, 1'b0};
    assign k_next  = r_k + 1'b1;
    assign c_next  = r_c + 1'b1;

    // Shared compare unit: pick the run source and order the two heads.
    assign a         = r_src_t ? i_t_qa : i_s_qa;
    assign b         = r_src_t ? i_t_qb : i_s_qb;
    assign cmp       = r_desc ? (a >= b) : (a <= b);
    assign take_left = (r_i < r_mid) && ((r_j >= r_hi) || cmp);

    assign o_busy = (r_state != SR_IDLE);
    assign o_done = (r_state == SR_DONE);

    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_front = r_front;
        n_desc  = r_desc;
        n_src_t = r_src_t;
        n_c     = r_c;
        n_w     = r_w;
        n_lo    = r_lo;
        n_mid   = r_mid;
        n_hi    = r_hi;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        o_mem   = '0;

        unique case (r_state)
            SR_IDLE: begin
                if (i_start) begin
                    n_n     = i_count;
                    n_front = i_front;
                    n_desc  = i_desc;
                    n_c     = '0;
                    n_state = (i_count == '0) ? SR_DONE : SR_CIN_RD;
                end
            end
            SR_CIN_RD: begin
                o_mem.ra = r_front + r_c[ADDR_W-1:0];
                n_state  = SR_CIN_WR;
            end
            SR_CIN_WR: begin
                o_mem.wa   = r_c[ADDR_W-1:0];
                o_mem.wd   = i_s_qa;
                o_mem.we_t = 1'b1;
                n_c        = c_next;
                if (c_next == r_n) begin
                    n_w     = t_cnt'(1);
                    n_src_t = 1'b1;
                    n_lo    = '0;
                    n_c     = '0;
                    n_state = (r_n > t_cnt'(1)) ? SR_SETUP : SR_COUT_RD;
                end else begin
                    n_state = SR_CIN_RD;
                end
            end
            SR_SETUP: begin
                n_mid   = (sum_mid > {1'b0, r_n}) ? r_n : sum_mid[CNT_W-1:0];
                n_hi    = (sum_hi > {1'b0, r_n}) ? r_n : sum_hi[CNT_W-1:0];
                n_i     = r_lo;
                n_j     = (sum_mid > {1'b0, r_n}) ? r_n : sum_mid[CNT_W-1:0];
                n_k     = r_lo;
                n_state = SR_M_RD;
            end
            SR_M_RD: begin
                o_mem.ra = r_i[ADDR_W-1:0];
                o_mem.rb = r_j[ADDR_W-1:0];
                n_state  = SR_M_WR;
            end
            SR_M_WR: begin
                // Write the chosen head into the memory that is not the source.
                o_mem.wa   = r_k[ADDR_W-1:0];
                o_mem.wd   = take_left ? a : b;
                o_mem.we_s = r_src_t;
                o_mem.we_t = !r_src_t;
                n_k        = k_next;
                if (take_left) begin
                    n_i = r_i + 1'b1;
                end else begin
                    n_j = r_j + 1'b1;
                end
                priority if (k_next != r_hi) begin
                    n_state = SR_M_RD;
                end else if (r_hi != r_n) begin
                    n_lo    = r_hi;
                    n_state = SR_SETUP;
                end else begin
                    // Pass complete: swap source and destination.
                    n_src_t = !r_src_t;
                    n_lo    = '0;
                    n_c     = '0;
                    if (w2 >= {1'b0, r_n}) begin
                        n_state = r_src_t ? SR_DONE : SR_COUT_RD;
                    end else begin
                        n_w     = w2[CNT_W-1:0];
                        n_state = SR_SETUP;
                    end
                end
            end
            SR_COUT_RD: begin
                o_mem.ra = r_c[ADDR_W-1:0];
                n_state  = SR_COUT_WR;
            end
            SR_COUT_WR: begin
                o_mem.wa   = r_c[ADDR_W-1:0];
                o_mem.wd   = i_t_qa;
                o_mem.we_s = 1'b1;
                n_c        = c_next;
                n_state    = (c_next == r_n) ? SR_DONE : SR_COUT_RD;
            end
            SR_DONE: begin
                n_state = SR_IDLE;
            end
            default: begin
                n_state = SR_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SR_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_n     <= n_n;
        r_front <= n_front;
        r_desc  <= n_desc;
        r_src_t <= n_src_t;
        r_c     <= n_c;
        r_w     <= n_w;
        r_lo    <= n_lo;
        r_mid   <= n_mid;
        r_hi    <= n_hi;
        r_i     <= n_i;
        r_j     <= n_j;
        r_k     <= n_k;
    end

endmodule

`default_nettype wire

FILE: sv/sortable_sequence_store_top.sv
// Ordered store of signed words with push back, pop front, pop back and a
// stable merge sort, ascending or descending.
// Input channel i_in_valid / o_in_stall / i_in carries one command per
// transfer; output channel o_out_valid / i_out_stall / o_out returns exactly
// one result per command, in command order.
// Steps per command, from input transfer to result in the output register:
//   push, pop from empty, push to full, skipped sort: straight to the result
//   pop front or pop back: one registered memory read first
//   sort of n items: copy into scratch, then ceil(log2 n) merge passes with a
//   setup step per run, then a copy back when the last pass lands in scratch.
//   The single compare unit handles one element at a time, since each choice
//   waits on a registered memory read.
// The input side stalls for the whole command; a new command is taken as
// soon as the previous result is in the output register, even while the
// receiver still stalls that result.
// A stalled result holds in the output register until taken.
// Reset (i_rst_n low at a clock edge) empties the store, clears the sorted
// mark and drops any pending result. Memory contents are not cleared.
`default_nettype none

module sortable_sequence_store_top (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire sss_pkg::t_in_item  i_in,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output sss_pkg::t_out_item      o_out
);

    import sss_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_POP  = 4'b0010,
        S_SORT = 4'b0100,
        S_EMIT = 4'b1000
    } t_top_state;

    t_top_state r_state, n_state;
    t_cnt       r_count, n_count;
    t_addr      r_front, n_front;
    logic       r_mark, n_mark;
    logic       r_dir, n_dir;
    logic       r_pop_front, n_pop_front;
    t_out_item  r_res, n_res;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out, n_out;

    logic       in_xfer;
    logic       sort_start;
    t_mem_req   top_mem;
    t_mem_req   sort_mem;
    t_mem_req   mem;
    logic       s_busy;
    logic       s_done;
    t_value     s_qa;
    t_value     s_qb;
    t_value     t_qa;
    t_value     t_qb;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_xfer     = i_in_valid && (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Store and scratch share addresses; the sorter owns them during a sort.
    assign mem = (r_state == S_SORT) ? sort_mem : top_mem;

    sss_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (VALUE_W)
    ) u_store (
        .i_clk (i_clk),
        .i_we  (mem.we_s),
        .i_wa  (mem.wa),
        .i_wd  (mem.wd),
        .i_ra  (mem.ra),
        .i_rb  (mem.rb),
        .o_qa  (s_qa),
        .o_qb  (s_qb)
    );

    sss_ram #(
        .ADDR_W (ADDR_W),
        .DATA_W (VALUE_W)
    ) u_scratch (
        .i_clk (i_clk),
        .i_we  (mem.we_t),
        .i_wa  (mem.wa),
        .i_wd  (mem.wd),
        .i_ra  (mem.ra),
        .i_rb  (mem.rb),
        .o_qa  (t_qa),
        .o_qb  (t_qb)
    );

    sss_sorter u_sorter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sort_start),
        .i_desc  (i_in.descending),
        .i_count (r_count),
        .i_front (r_front),
        .i_s_qa  (s_qa),
        .i_s_qb  (s_qb),
        .i_t_qa  (t_qa),
        .i_t_qb  (t_qb),
        .o_mem   (sort_mem),
        .o_busy  (s_busy),
        .o_done  (s_done)
    );

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_front     = r_front;
        n_mark      = r_mark;
        n_dir       = r_dir;
        n_pop_front = r_pop_front;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        sort_start  = 1'b0;

        // Idle request: pop read address and push write, straight from state.
        top_mem    = '0;
        top_mem.ra = (i_in.command == CMD_POP_FRONT) ? r_front
                   : r_front + (r_count[ADDR_W-1:0] - 1'b1);
        top_mem.wa = r_front + r_count[ADDR_W-1:0];
        top_mem.wd = i_in.data_value;

        // Drop the result once the receiver takes it.
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    n_res.popped_value = '0;
                    n_res.item_count   = r_count;
                    n_res.status       = STATUS_OK;
                    n_state            = S_EMIT;
                    unique case (i_in.command)
                        CMD_PUSH: begin
                            if (r_count == t_cnt'(DEPTH)) begin
                                n_res.status = STATUS_FULL;
                            end else begin
                                top_mem.we_s     = 1'b1;
                                n_count          = r_count + 1'b1;
                                n_res.item_count = r_count + 1'b1;
                                n_mark           = 1'b0;
                            end
                        end
                        CMD_POP_FRONT, CMD_POP_BACK: begin
                            if (r_count == '0) begin
                                n_res.status = STATUS_EMPTY;
                            end else begin
                                n_pop_front = (i_in.command == CMD_POP_FRONT);
                                n_state     = S_POP;
                            end
                        end
                        CMD_SORT: begin
                            if (!(r_mark && (r_dir == i_in.descending))) begin
                                sort_start = 1'b1;
                                n_dir      = i_in.descending;
                                n_state    = S_SORT;
                            end
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_POP: begin
                n_res.popped_value = s_qa;
                n_res.item_count   = r_count - 1'b1;
                n_res.status       = STATUS_OK;
                n_count            = r_count - 1'b1;
                n_mark             = 1'b0;
                if (r_pop_front) begin
                    n_front = r_front + 1'b1;
                end
                n_state = S_EMIT;
            end
            S_SORT: begin
                if (s_done) begin
                    n_front = '0;
                    n_mark  = 1'b1;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // Load the output register once it is free or being taken.
                if (!r_out_valid || !i_out_stall) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_front     <= '0;
            r_mark      <= 1'b0;
            r_dir       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_front     <= n_front;
            r_mark      <= n_mark;
            r_dir       <= n_dir;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pop_front <= n_pop_front;
        r_res       <= n_res;
        r_out       <= n_out;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_cnt'(DEPTH))
        else $error("item count above depth");

    a_sorter_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_busy |-> (r_state == S_SORT))
        else $error("sorter active outside sort state");

    a_sort_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_done |=> (r_front == '0) && r_mark)
        else $error("sort finished without reset front and sorted mark");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out.status == STATUS_FULL))
            |-> (o_out.item_count == 9'(DEPTH)))
        else $error("full status with store not full");
`endif

endmodule

`default_nettype wire

FILE: test/sortable_sequence_store_top_tb.sv
`default_nettype none

module sortable_sequence_store_top_tb;

    import sss_pkg::*;

    localparam int ITEM_TARGET    = 1300;
    localparam int QUIET_TAIL     = 150;
    localparam int WATCHDOG_LIMIT = 40000;
    localparam int DIRECTED_ROWS  = 24;

    // One row of the directed table: the command and, where it is obvious,
    // the result typed in by hand.
    typedef struct packed {
        t_in_item  stim;
        logic      typed;
        t_out_item want;
    } t_directed_row;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    t_in_item  in_item   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    // Shadow copy of the sequence, front at index 0.
    t_value    stored_words[$];
    logic      sorted_flag = 1'b0;
    logic      sorted_desc = 1'b0;

    t_out_item expected_results[$];

    int fail_count  = 0;
    int items_sent  = 0;
    int fills_done  = 0;
    int idle_cycles = 0;
    int stall_left  = 0;
    bit idle_on     = 1'b1;

    t_directed_row directed_rows [DIRECTED_ROWS] = '{
        // empty store: pops flag, sorts are no-ops
        '{'{CMD_POP_FRONT, 32'sh0, 1'b0}, 1'b1, '{32'sh0, 9'd0, STATUS_EMPTY}},
        '{'{CMD_POP_BACK, 32'shffffffff, 1'b1}, 1'b1, '{32'sh0, 9'd0, STATUS_EMPTY}},
        '{'{CMD_SORT, 32'sh0, 1'b0}, 1'b1, '{32'sh0, 9'd0, STATUS_OK}},
        '{'{CMD_SORT, 32'sh0, 1'b1}, 1'b1, '{32'sh0, 9'd0, STATUS_OK}},
        // extremes and bit patterns, one duplicate
        '{'{CMD_PUSH, 32'sh7fffffff, 1'b0}, 1'b1, '{32'sh0, 9'd1, STATUS_OK}},
        '{'{CMD_PUSH, 32'sh80000000, 1'b1}, 1'b1, '{32'sh0, 9'd2, STATUS_OK}},
        '{'{CMD_PUSH, 32'sh0, 1'b0}, 1'b1, '{32'sh0, 9'd3, STATUS_OK}},
        '{'{CMD_PUSH, 32'shffffffff, 1'b0}, 1'b1, '{32'sh0, 9'd4, STATUS_OK}},
        '{'{CMD_PUSH, 32'sh1, 1'b0}, 1'b1, '{32'sh0, 9'd5, STATUS_OK}},
        '{'{CMD_PUSH, 32'sh55555555, 1'b1}, 1'b1, '{32'sh0, 9'd6, STATUS_OK}},
        '{'{CMD_PUSH, 32'shaaaaaaaa, 1'b0}, 1'b1, '{32'sh0, 9'd7, STATUS_OK}},
        '{'{CMD_PUSH, 32'sh0, 1'b0}, 1'b1, '{32'sh0, 9'd8, STATUS_OK}},
        // ascending sort, then the same sort again (skipped)
        '{'{CMD_SORT, 32'sh7fffffff, 1'b0}, 1'b1, '{32'sh0, 9'd8, STATUS_OK}},
        '{'{CMD_SORT, 32'sh80000000, 1'b0}, 1'b1, '{32'sh0, 9'd8, STATUS_OK}},
        '{'{CMD_POP_FRONT, 32'sh0, 1'b0}, 1'b1, '{32'sh80000000, 9'd7, STATUS_OK}},
        '{'{CMD_POP_BACK, 32'sh0, 1'b0}, 1'b1, '{32'sh7fffffff, 9'd6, STATUS_OK}},
        // direction changes, checked against the predictor
        '{'{CMD_SORT, 32'sh0, 1'b1}, 1'b0, '0},
        '{'{CMD_POP_FRONT, 32'shffffffff, 1'b1}, 1'b0, '0},
        '{'{CMD_POP_BACK, 32'sh0, 1'b0}, 1'b0, '0},
        '{'{CMD_SORT, 32'shffffffff, 1'b1}, 1'b0, '0},
        '{'{CMD_SORT, 32'sh0, 1'b0}, 1'b0, '0},
        '{'{CMD_POP_FRONT, 32'sh0, 1'b1}, 1'b0, '0},
        '{'{CMD_PUSH, 32'sh12345678, 1'b1}, 1'b0, '0},
        '{'{CMD_POP_BACK, 32'sh0, 1'b1}, 1'b0, '0}
    };

    sortable_sequence_store_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    always #10 clk = ~clk;

    // Stable insertion sort: shift only strictly out-of-order neighbors so
    // equal values keep their order.
    function automatic void order_words(input logic desc);
        t_value held;
        int     j;
        for (int i = 1; i < stored_words.size(); i++) begin
            held = stored_words[i];
            j    = i - 1;
            while (j >= 0 && (desc ? (stored_words[j] < held) : (stored_words[j] > held))) begin
                stored_words[j + 1] = stored_words[j];
                j--;
            end
            stored_words[j + 1] = held;
        end
    endfunction

    // Apply one command to the shadow sequence and return its result.
    function automatic t_out_item predict_result(input t_in_item it);
        t_out_item r;
        r.popped_value = '0;
        r.status       = STATUS_OK;
        case (it.command)
            CMD_PUSH: begin
                if (stored_words.size() >= DEPTH) begin
                    r.status = STATUS_FULL;
                end else begin
                    stored_words.push_back(it.data_value);
                    sorted_flag = 1'b0;
                end
            end
            CMD_POP_FRONT: begin
                if (stored_words.size() == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    r.popped_value = stored_words.pop_front();
                    sorted_flag    = 1'b0;
                end
            end
            CMD_POP_BACK: begin
                if (stored_words.size() == 0) begin
                    r.status = STATUS_EMPTY;
                end else begin
                    r.popped_value = stored_words.pop_back();
                    sorted_flag    = 1'b0;
                end
            end
            CMD_SORT: begin
                if (!(sorted_flag && sorted_desc == it.descending)) begin
                    sorted_desc = it.descending;
                    order_words(it.descending);
                    sorted_flag = 1'b1;
                end
            end
        endcase
        r.item_count = 9'(stored_words.size());
        return r;
    endfunction

    function automatic void check_result(input t_out_item got);
        t_out_item want;
        if (expected_results.size() == 0) begin
            $error("result with nothing pending: popped_value %0d item_count %0d status %0d",
                   got.popped_value, got.item_count, got.status);
            fail_count++;
        end else begin
            want = expected_results.pop_front();
            if (got.popped_value !== want.popped_value) begin
                $error("popped_value: expected %0d, got %0d", want.popped_value, got.popped_value);
                fail_count++;
            end
            if (got.item_count !== want.item_count) begin
                $error("item_count: expected %0d, got %0d", want.item_count, got.item_count);
                fail_count++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                fail_count++;
            end
        end
    endfunction

    function automatic t_value rand_word();
        case ($urandom_range(0, 7))
            0:       return 32'sh7fffffff;
            1:       return 32'sh80000000;
            2, 3:    return t_value'(int'($urandom_range(0, 6)) - 3);
            default: return t_value'($urandom);
        endcase
    endfunction

    function automatic logic rand_desc();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic t_cmd pick_pop();
        return $urandom_range(0, 1) ? CMD_POP_FRONT : CMD_POP_BACK;
    endfunction

    // Offer one command, hold it until the transfer, then record what the
    // block should answer. A random idle burst may come first.
    task automatic send_item(input t_in_item it, input logic has_typed,
                             input t_out_item typed_res);
        t_out_item predicted;
        idle_on = (items_sent < ITEM_TARGET - QUIET_TAIL);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item  <= it;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        predicted = predict_result(it);
        expected_results.push_back(has_typed ? typed_res : predicted);
        items_sent++;
    endtask

    task automatic issue_cmd(input t_cmd c, input logic desc);
        t_in_item it;
        it.command    = c;
        it.data_value = rand_word();
        it.descending = desc;
        send_item(it, 1'b0, '0);
    endtask

    // Fill to the top, bounce off the full store, sort, wrap the ring and
    // sort the other way, then drain past empty.
    task automatic run_fill();
        logic d;
        int   k;
        d = rand_desc();
        while (stored_words.size() < DEPTH) issue_cmd(CMD_PUSH, rand_desc());
        issue_cmd(CMD_PUSH, rand_desc());
        issue_cmd(CMD_SORT, d);
        issue_cmd(CMD_PUSH, rand_desc());
        issue_cmd(CMD_SORT, d);
        k = $urandom_range(20, 120);
        repeat (k) issue_cmd(CMD_POP_FRONT, rand_desc());
        repeat ($urandom_range(10, k)) issue_cmd(CMD_PUSH, rand_desc());
        issue_cmd(CMD_SORT, ~d);
        while (stored_words.size() != 0) issue_cmd(pick_pop(), rand_desc());
        issue_cmd(pick_pop(), rand_desc());
        fills_done++;
    endtask

    // Small well-formed burst: pushes, a sort or two, mixed traffic, and
    // sometimes a drain past empty.
    task automatic run_short_sequence();
        logic d;
        d = rand_desc();
        if (stored_words.size() > 48) begin
            repeat ($urandom_range(8, 24)) issue_cmd(pick_pop(), rand_desc());
        end
        repeat ($urandom_range(1, 12)) issue_cmd(CMD_PUSH, rand_desc());
        issue_cmd(CMD_SORT, d);
        if ($urandom_range(0, 1) != 0) issue_cmd(CMD_SORT, d);
        if ($urandom_range(0, 2) == 0) issue_cmd(CMD_SORT, ~d);
        repeat ($urandom_range(1, 8)) begin
            case ($urandom_range(0, 5))
                0, 1:    issue_cmd(CMD_POP_FRONT, rand_desc());
                2, 3:    issue_cmd(CMD_POP_BACK, rand_desc());
                4:       issue_cmd(CMD_PUSH, rand_desc());
                default: issue_cmd(CMD_SORT, rand_desc());
            endcase
        end
        if ($urandom_range(0, 3) == 0) begin
            while (stored_words.size() != 0) issue_cmd(pick_pop(), rand_desc());
            repeat ($urandom_range(1, 2)) issue_cmd(pick_pop(), rand_desc());
        end
    endtask

    // Result side: take transfers, stall in random bursts.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else begin
            if (out_valid && !out_stall) check_result(out_item);
            if (stall_left != 0) begin
                out_stall  <= 1'b1;
                stall_left <= stall_left - 1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                out_stall  <= 1'b1;
                stall_left <= $urandom_range(0, 2);
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Drop the run when no transfer happens on either side for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[r]) begin
            send_item(directed_rows[r].stim, directed_rows[r].typed, directed_rows[r].want);
        end

        run_fill();
        while (items_sent < ITEM_TARGET) begin
            case ($urandom_range(0, 15))
                0: begin
                    repeat ($urandom_range(1, 6)) begin
                        issue_cmd(t_cmd'($urandom_range(0, 3)), rand_desc());
                    end
                end
                1: begin
                    // A full fill is long; start one only early in the run.
                    if (fills_done < 2 && items_sent < ITEM_TARGET / 2
                            && $urandom_range(0, 3) == 0) begin
                        run_fill();
                    end else begin
                        run_short_sequence();
                    end
                end
                default: run_short_sequence();
            endcase
        end

        in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
